### hw/rtl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and block-function helpers for the stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;

   localparam logic [2:0] REG_KEY_PART0     = 3'd0;
   localparam logic [2:0] REG_KEY_PART1     = 3'd1;
   localparam logic [2:0] REG_KEY_PART2     = 3'd2;
   localparam logic [2:0] REG_KEY_PART3     = 3'd3;
   localparam logic [2:0] REG_NONCE_LOW     = 3'd4;
   localparam logic [2:0] REG_NONCE_HIGH    = 3'd5;
   localparam logic [2:0] REG_COUNTER_START = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [7:0] result_byte;
      logic       last_out;
   } rsp_type;

   typedef struct packed {
      req_type item;
      logic    msg_start;
   } work_item_type;

   typedef struct packed {
      logic [63:0] key_part0;
      logic [63:0] key_part1;
      logic [63:0] key_part2;
      logic [63:0] key_part3;
      logic [63:0] nonce_low;
      logic [31:0] nonce_high;
      logic [31:0] counter_start;
   } cfg_type;

   typedef logic [15:0][31:0] block_state_type;
   typedef logic [3:0][31:0]  quad_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   // a, b, c, d in element 0..3
   function automatic quad_type mix_quad(input quad_type q);
      logic [31:0] a, b, c, d;
      a = q[0];
      b = q[1];
      c = q[2];
      d = q[3];
      a = a + b;  d = rotl(d ^ a, 16);
      c = c + d;  b = rotl(b ^ c, 12);
      a = a + b;  d = rotl(d ^ a, 8);
      c = c + d;  b = rotl(b ^ c, 7);
      mix_quad[0] = a;
      mix_quad[1] = b;
      mix_quad[2] = c;
      mix_quad[3] = d;
   endfunction

   function automatic block_state_type init_state(input cfg_type cfg,
                                                  input logic [31:0] count);
      block_state_type s;
      s[0]  = SIGMA0;
      s[1]  = SIGMA1;
      s[2]  = SIGMA2;
      s[3]  = SIGMA3;
      s[4]  = cfg.key_part0[31:0];
      s[5]  = cfg.key_part0[63:32];
      s[6]  = cfg.key_part1[31:0];
      s[7]  = cfg.key_part1[63:32];
      s[8]  = cfg.key_part2[31:0];
      s[9]  = cfg.key_part2[63:32];
      s[10] = cfg.key_part3[31:0];
      s[11] = cfg.key_part3[63:32];
      s[12] = count;
      s[13] = cfg.nonce_low[31:0];
      s[14] = cfg.nonce_low[63:32];
      s[15] = cfg.nonce_high;
      init_state = s;
   endfunction

endpackage

### hw/rtl/cc20_front.sv
// ----------------------------------------------------------------------------
// cc20_front
// Input queue: takes bytes, marks the first byte of each message, and holds
// them until the keystream engine is ready.
// ----------------------------------------------------------------------------
module cc20_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cc20_pkg::req_type          req_payload,
   output logic                       full,
   input  logic                       deq,
   output logic                       head_valid,
   output cc20_pkg::work_item_type    head
);

   cc20_pkg::work_item_type entry_ff [cc20_pkg::QUEUE_DEPTH];
   cc20_pkg::work_item_type entry_in;
   logic [cc20_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cc20_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cc20_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             start_ff, start_in;
   logic                             do_push, do_pop;

   assign full       = (count_ff == cc20_pkg::QUEUE_CNT_W'(cc20_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = deq && head_valid;

   always_comb begin
      entry_in.item      = req_payload;
      entry_in.msg_start = start_ff;
      wr_ptr_in = do_push ? wr_ptr_ff + cc20_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + cc20_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + cc20_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - cc20_pkg::QUEUE_CNT_W'(1);
      end
      // the byte after an end-of-message byte opens a new message
      start_in = do_push ? req_payload.message_end : start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         start_ff  <= 1'b1;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         start_ff  <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

### hw/rtl/cc20_back.sv
// ----------------------------------------------------------------------------
// cc20_back
// Keystream engine: builds 64-byte blocks with one shared quarter-round unit
// and XORs queued bytes with the keystream into an output register.
// ----------------------------------------------------------------------------
module cc20_back #(
   parameter int ROUNDS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cc20_pkg::cfg_type          cfg,
   input  logic                       head_valid,
   input  cc20_pkg::work_item_type    head,
   output logic                       deq,
   output logic                       empty,
   input  logic                       pop,
   output cc20_pkg::rsp_type          rsp_payload
);

   localparam int QR_TOTAL = 4 * ROUNDS;
   localparam int QR_CNT_W = $clog2(QR_TOTAL);
   localparam logic [QR_CNT_W-1:0] QR_LAST = QR_CNT_W'(QR_TOTAL - 1);

   typedef enum logic [2:0] {
      ST_READY = 3'b001,
      ST_ROUND = 3'b010,
      ST_FINAL = 3'b100
   } back_state_type;

   back_state_type              state_ff, state_in;
   cc20_pkg::block_state_type   work_ff, work_in;
   cc20_pkg::block_state_type   ks_ff, ks_in;
   cc20_pkg::block_state_type   tmp, rotated, init_cur;
   cc20_pkg::quad_type          qr_in, qr_out;
   logic [31:0]                 count_ff, count_in;
   logic [5:0]                  pos_ff, pos_in;
   logic                        first_built_ff, first_built_in;
   logic [QR_CNT_W-1:0]         qr_cnt_ff, qr_cnt_in;
   logic                        out_valid_ff, out_valid_in;
   cc20_pkg::rsp_type           out_ff, out_in;
   logic                        diag, out_free, build_first, consume;
   logic [31:0]                 ks_word;
   logic [7:0]                  ks_byte;

   assign empty       = !out_valid_ff;
   assign rsp_payload = out_ff;
   assign out_free    = !out_valid_ff || pop;
   assign build_first = (state_ff == ST_READY) && head_valid && head.msg_start
                        && !first_built_ff;
   assign consume     = (state_ff == ST_READY) && head_valid && !build_first && out_free;
   assign deq         = consume;

   assign ks_word = ks_ff[pos_ff[5:2]];
   assign ks_byte = ks_word[{pos_ff[1:0], 3'b000} +: 8];

   // the state is rotated one column after every quarter round, so the
   // unit always works on column 0 or on the main diagonal
   assign diag     = qr_cnt_ff[2];
   assign init_cur = cc20_pkg::init_state(cfg, count_ff);

   always_comb begin
      qr_in[0] = work_ff[0];
      qr_in[1] = diag ? work_ff[5]  : work_ff[4];
      qr_in[2] = diag ? work_ff[10] : work_ff[8];
      qr_in[3] = diag ? work_ff[15] : work_ff[12];
      qr_out   = cc20_pkg::mix_quad(qr_in);
      tmp      = work_ff;
      tmp[0]   = qr_out[0];
      if (diag) begin
         tmp[5]  = qr_out[1];
         tmp[10] = qr_out[2];
         tmp[15] = qr_out[3];
      end else begin
         tmp[4]  = qr_out[1];
         tmp[8]  = qr_out[2];
         tmp[12] = qr_out[3];
      end
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 4; j++) begin
            rotated[r*4 + j] = tmp[r*4 + ((j + 1) % 4)];
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      work_in        = work_ff;
      ks_in          = ks_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      first_built_in = first_built_ff;
      qr_cnt_in      = qr_cnt_ff;
      out_valid_in   = out_valid_ff && !pop;
      out_in         = out_ff;

      unique case (state_ff)
         ST_READY: begin
            if (build_first) begin
               count_in  = cfg.counter_start;
               pos_in    = '0;
               work_in   = cc20_pkg::init_state(cfg, cfg.counter_start);
               qr_cnt_in = '0;
               state_in  = ST_ROUND;
            end else if (consume) begin
               out_valid_in       = 1'b1;
               out_in.result_byte = head.item.data_byte ^ ks_byte;
               out_in.last_out    = head.item.message_end;
               first_built_in     = 1'b0;
               if (head.item.message_end) begin
                  pos_in = '0;
               end else if (pos_ff == 6'd63) begin
                  pos_in    = '0;
                  count_in  = count_ff + 32'd1;
                  work_in   = cc20_pkg::init_state(cfg, count_ff + 32'd1);
                  qr_cnt_in = '0;
                  state_in  = ST_ROUND;
               end else begin
                  pos_in = pos_ff + 6'd1;
               end
            end
         end
         ST_ROUND: begin
            work_in   = rotated;
            qr_cnt_in = qr_cnt_ff + QR_CNT_W'(1);
            if (qr_cnt_ff == QR_LAST) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < 16; i++) begin
               ks_in[i] = work_ff[i] + init_cur[i];
            end
            first_built_in = 1'b1;
            state_in       = ST_READY;
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_READY;
         count_ff       <= '0;
         pos_ff         <= '0;
         first_built_ff <= 1'b0;
         qr_cnt_ff      <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         pos_ff         <= pos_in;
         first_built_ff <= first_built_in;
         qr_cnt_ff      <= qr_cnt_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      ks_ff   <= ks_in;
      out_ff  <= out_in;
   end

endmodule

### hw/rtl/chacha20_stream_cipher.sv
// ChaCha20 stream cipher, one byte per transaction. Within a keystream block
// a byte is transformed every cycle while a byte is queued and the output
// register is free; each 64-byte block is built by a single quarter-round
// unit doing one quarter round per cycle, and bytes are not processed while
// a block is built; the first byte of a message waits for its block.
// A four-entry input queue keeps accepting bytes while a block is built.
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// Top level: register file on the APB-style port, input queue and keystream
// engine.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher #(
   parameter int ROUNDS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  cc20_pkg::req_type                   req_payload,
   output logic                                empty,
   input  logic                                pop,
   output cc20_pkg::rsp_type                   rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cc20_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [cc20_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [cc20_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   cc20_pkg::cfg_type        cfg_ff, cfg_in;
   cc20_pkg::work_item_type  head;
   logic                     head_valid, deq, csr_write;
   logic [2:0]               csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[5:3];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            cc20_pkg::REG_KEY_PART0:     cfg_in.key_part0     = pwdata;
            cc20_pkg::REG_KEY_PART1:     cfg_in.key_part1     = pwdata;
            cc20_pkg::REG_KEY_PART2:     cfg_in.key_part2     = pwdata;
            cc20_pkg::REG_KEY_PART3:     cfg_in.key_part3     = pwdata;
            cc20_pkg::REG_NONCE_LOW:     cfg_in.nonce_low     = pwdata;
            cc20_pkg::REG_NONCE_HIGH:    cfg_in.nonce_high    = pwdata[31:0];
            cc20_pkg::REG_COUNTER_START: cfg_in.counter_start = pwdata[31:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         cc20_pkg::REG_KEY_PART0:     prdata = cfg_ff.key_part0;
         cc20_pkg::REG_KEY_PART1:     prdata = cfg_ff.key_part1;
         cc20_pkg::REG_KEY_PART2:     prdata = cfg_ff.key_part2;
         cc20_pkg::REG_KEY_PART3:     prdata = cfg_ff.key_part3;
         cc20_pkg::REG_NONCE_LOW:     prdata = cfg_ff.nonce_low;
         cc20_pkg::REG_NONCE_HIGH:    prdata = {32'd0, cfg_ff.nonce_high};
         cc20_pkg::REG_COUNTER_START: prdata = {32'd0, cfg_ff.counter_start};
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cc20_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_payload (req_payload),
      .full        (full),
      .deq         (deq),
      .head_valid  (head_valid),
      .head        (head)
   );

   cc20_back #(
      .ROUNDS (ROUNDS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_valid  (head_valid),
      .head        (head),
      .deq         (deq),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload)
   );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-serial ChaCha20 cipher: a directed table
// (known keystream bytes after reset and for the standard sample key, extreme
// registers) followed by random messages under several idle and stall mixes.
// Results are compared with typed known answers or an in-bench keystream model.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NUM_ROUNDS      = 20;  // typed keystream bytes below assume 20
   localparam int DRAIN_CYCLES    = 4 * NUM_ROUNDS + 20;
   localparam int HOLD_CYCLES     = 400;
   localparam int ITEMS_PER_PHASE = 175;
   localparam int NUM_PHASES      = 8;
   localparam int CYCLE_LIMIT     = 1000000;

   // one past the last register, writes there must be dropped
   localparam logic [2:0] REG_BEYOND_LIST = 3'd7;

   typedef struct {
      bit                is_cfg;
      logic [2:0]        reg_idx;
      logic [63:0]       reg_val;
      cc20_pkg::req_type item;
      bit                fixed_valid;
      cc20_pkg::rsp_type fixed_rsp;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            push = 1'b0;
   logic                            full;
   cc20_pkg::req_type               req_payload = '0;
   logic                            empty;
   logic                            pop = 1'b0;
   cc20_pkg::rsp_type               rsp_payload;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [cc20_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [cc20_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [cc20_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   // known-answer bytes travel alongside the payload
   bit                fixed_valid_drv = 1'b0;
   cc20_pkg::rsp_type fixed_drv = '0;

   // values seen just before each rising edge
   bit                smp_reset = 1'b1;
   bit                smp_req_fire = 1'b0;
   bit                smp_rsp_fire = 1'b0;
   bit                smp_pready = 1'b0;
   cc20_pkg::req_type smp_item;
   cc20_pkg::rsp_type smp_rsp;
   bit                smp_fixed_valid;
   cc20_pkg::rsp_type smp_fixed;

   int unsigned tx_idle_pct = 0;
   int unsigned rx_stall_pct = 0;
   bit          hold_request = 1'b0;
   int          error_count = 0;
   int          cycle_count = 0;

   // register copy
   logic [63:0] mdl_key [4];
   logic [63:0] mdl_nonce_lo = '0;
   logic [31:0] mdl_nonce_hi = '0;
   logic [31:0] mdl_ctr_start = '0;

   // keystream state
   logic [31:0] ks_block [16];
   logic [31:0] mix_w [16];
   logic [31:0] blk_ctr = '0;
   logic [5:0]  ks_pos = '0;
   bit          msg_open = 1'b0;

   cc20_pkg::rsp_type cipher_out_q [$];
   stim_row_type      dir_rows [$];

   chacha20_stream_cipher #(
      .ROUNDS(NUM_ROUNDS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      smp_reset       = reset;
      smp_req_fire    = push && !full;
      smp_rsp_fire    = pop && !empty;
      smp_pready      = pready;
      smp_item        = req_payload;
      smp_rsp         = rsp_payload;
      smp_fixed_valid = fixed_valid_drv;
      smp_fixed       = fixed_drv;
   end

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
      logic [63:0] dbl;
      dbl = {v, v} << n;
      return dbl[63:32];
   endfunction

   function automatic void mix_quarter(input int a, input int b, input int c, input int d);
      mix_w[a] = mix_w[a] + mix_w[b];  mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 16);
      mix_w[c] = mix_w[c] + mix_w[d];  mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 12);
      mix_w[a] = mix_w[a] + mix_w[b];  mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 8);
      mix_w[c] = mix_w[c] + mix_w[d];  mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 7);
   endfunction

   function automatic void make_keystream_block();
      logic [31:0] seed_w [16];
      int          p;
      int          r;
      seed_w[0] = cc20_pkg::SIGMA0;
      seed_w[1] = cc20_pkg::SIGMA1;
      seed_w[2] = cc20_pkg::SIGMA2;
      seed_w[3] = cc20_pkg::SIGMA3;
      for (p = 0; p < 4; p++) begin
         seed_w[4 + 2 * p] = mdl_key[p][31:0];
         seed_w[5 + 2 * p] = mdl_key[p][63:32];
      end
      seed_w[12] = blk_ctr;
      seed_w[13] = mdl_nonce_lo[31:0];
      seed_w[14] = mdl_nonce_lo[63:32];
      seed_w[15] = mdl_nonce_hi;
      for (p = 0; p < 16; p++) mix_w[p] = seed_w[p];
      // odd round counts finish on a column round
      for (r = 0; r < NUM_ROUNDS; r++) begin
         if (r % 2 == 0) begin
            mix_quarter(0, 4, 8, 12);
            mix_quarter(1, 5, 9, 13);
            mix_quarter(2, 6, 10, 14);
            mix_quarter(3, 7, 11, 15);
         end else begin
            mix_quarter(0, 5, 10, 15);
            mix_quarter(1, 6, 11, 12);
            mix_quarter(2, 7, 8, 13);
            mix_quarter(3, 4, 9, 14);
         end
      end
      for (p = 0; p < 16; p++) ks_block[p] = mix_w[p] + seed_w[p];
   endfunction

   function automatic cc20_pkg::rsp_type keystream_xor(input cc20_pkg::req_type item);
      cc20_pkg::rsp_type res;
      logic [31:0]       word;
      if (!msg_open) begin
         blk_ctr = mdl_ctr_start;
         ks_pos = '0;
         make_keystream_block();
         msg_open = 1'b1;
      end
      word = ks_block[ks_pos[5:2]];
      res.result_byte = item.data_byte ^ word[8 * ks_pos[1:0] +: 8];
      res.last_out = item.message_end;
      // end of message wins over a block boundary
      if (item.message_end) begin
         msg_open = 1'b0;
         ks_pos = '0;
      end else if (ks_pos == 6'd63) begin
         ks_pos = '0;
         blk_ctr = blk_ctr + 32'd1;
         make_keystream_block();
      end else begin
         ks_pos = ks_pos + 6'd1;
      end
      return res;
   endfunction

   function automatic void mdl_reg_write(input logic [2:0] idx, input logic [63:0] val);
      unique case (idx)
         cc20_pkg::REG_KEY_PART0:     mdl_key[0] = val;
         cc20_pkg::REG_KEY_PART1:     mdl_key[1] = val;
         cc20_pkg::REG_KEY_PART2:     mdl_key[2] = val;
         cc20_pkg::REG_KEY_PART3:     mdl_key[3] = val;
         cc20_pkg::REG_NONCE_LOW:     mdl_nonce_lo = val;
         cc20_pkg::REG_NONCE_HIGH:    mdl_nonce_hi = val[31:0];
         cc20_pkg::REG_COUNTER_START: mdl_ctr_start = val[31:0];
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : result_check
      cc20_pkg::rsp_type want;
      if (!smp_reset) begin
         if (smp_req_fire) begin
            want = keystream_xor(smp_item);
            if (smp_fixed_valid) want = smp_fixed;
            cipher_out_q.push_back(want);
         end
         if (smp_rsp_fire) begin
            if (cipher_out_q.size() == 0) begin
               $error("result transaction with nothing outstanding: result_byte %h last_out %b",
                      smp_rsp.result_byte, smp_rsp.last_out);
               error_count++;
            end else begin
               want = cipher_out_q.pop_front();
               if (smp_rsp.result_byte !== want.result_byte) begin
                  $error("result_byte: expected %h, got %h",
                         want.result_byte, smp_rsp.result_byte);
                  error_count++;
               end
               if (smp_rsp.last_out !== want.last_out) begin
                  $error("last_out: expected %b, got %b", want.last_out, smp_rsp.last_out);
                  error_count++;
               end
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin : rx_side
      forever begin
         @(posedge clock);
         if (hold_request) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         pop <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   task automatic send_byte(input cc20_pkg::req_type item, input bit has_fixed,
                            input cc20_pkg::rsp_type fixed);
      while ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_payload <= item;
      fixed_valid_drv <= has_fixed;
      fixed_drv <= fixed;
      @(posedge clock);
      while (!smp_req_fire) @(posedge clock);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      do @(posedge clock); while (cipher_out_q.size() != 0);
      // a block build may still run after the last result
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!smp_pready) @(posedge clock);
      mdl_reg_write(idx, val);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void add_cfg(input logic [2:0] idx, input logic [63:0] val);
      stim_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_byte(input logic [7:0] data, input bit msg_end,
                                    input bit has_fixed, input logic [7:0] fixed_byte);
      stim_row_type row;
      row = '{default: '0};
      row.item.data_byte = data;
      row.item.message_end = msg_end;
      row.fixed_valid = has_fixed;
      row.fixed_rsp.result_byte = fixed_byte;
      row.fixed_rsp.last_out = msg_end;
      dir_rows.push_back(row);
   endfunction

   initial begin : stimulus
      int                k;
      int                phase;
      int                ri;
      int                msg_left;
      logic [63:0]       v;
      cc20_pkg::req_type item;

      for (k = 0; k < 4; k++) mdl_key[k] = '0;
      msg_left = 0;

      // all-zero key, nonce and counter straight after reset
      add_byte(8'h00, 1'b0, 1'b1, 8'h76);
      add_byte(8'hff, 1'b0, 1'b1, 8'h47);
      add_byte(8'h00, 1'b1, 1'b1, 8'he0);
      // standard sample: key 00..1f, counter 1; upper bits of 32-bit regs dropped
      add_cfg(cc20_pkg::REG_KEY_PART0, 64'h0706050403020100);
      add_cfg(cc20_pkg::REG_KEY_PART1, 64'h0f0e0d0c0b0a0908);
      add_cfg(cc20_pkg::REG_KEY_PART2, 64'h1716151413121110);
      add_cfg(cc20_pkg::REG_KEY_PART3, 64'h1f1e1d1c1b1a1918);
      add_cfg(cc20_pkg::REG_NONCE_LOW, 64'h4a00000000000000);
      add_cfg(cc20_pkg::REG_NONCE_HIGH, 64'hdeadbeef00000000);
      add_cfg(cc20_pkg::REG_COUNTER_START, 64'hffffffff00000001);
      add_cfg(REG_BEYOND_LIST, 64'h0123456789abcdef);
      add_byte(8'h4c, 1'b0, 1'b1, 8'h6e);
      add_byte(8'h61, 1'b0, 1'b1, 8'h2e);
      add_byte(8'h64, 1'b0, 1'b1, 8'h35);
      add_byte(8'h69, 1'b0, 1'b1, 8'h9a);
      add_byte(8'h65, 1'b0, 1'b1, 8'h25);
      add_byte(8'h73, 1'b0, 1'b1, 8'h68);
      add_byte(8'h20, 1'b0, 1'b1, 8'hf9);
      add_byte(8'h61, 1'b1, 1'b1, 8'h80);
      // everything at its maximum
      add_cfg(cc20_pkg::REG_KEY_PART0, '1);
      add_cfg(cc20_pkg::REG_KEY_PART1, '1);
      add_cfg(cc20_pkg::REG_KEY_PART2, '1);
      add_cfg(cc20_pkg::REG_KEY_PART3, '1);
      add_cfg(cc20_pkg::REG_NONCE_LOW, '1);
      add_cfg(cc20_pkg::REG_NONCE_HIGH, '1);
      add_cfg(cc20_pkg::REG_COUNTER_START, '1);
      add_byte(8'hff, 1'b0, 1'b0, 8'h00);
      add_byte(8'h00, 1'b0, 1'b0, 8'h00);
      add_byte(8'hff, 1'b1, 1'b0, 8'h00);
      add_byte(8'h80, 1'b1, 1'b0, 8'h00);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            wait_drained();
            csr_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
         end else begin
            send_byte(dir_rows[i].item, dir_rows[i].fixed_valid, dir_rows[i].fixed_rsp);
         end
      end

      // random messages; a message may stay open across a register change
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         for (ri = cc20_pkg::REG_KEY_PART0; ri <= REG_BEYOND_LIST; ri++) begin
            case (phase)
               0: v = '1;
               3: v = '0;
               default: v = {$urandom, $urandom};
            endcase
            // counter near the top so the block count wraps
            if (ri == cc20_pkg::REG_COUNTER_START && phase % 2 == 1)
               v[31:0] = 32'hffffffff - $urandom_range(1);
            csr_write(ri[2:0], v);
         end
         case (phase % 4)
            0: begin
               tx_idle_pct = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_idle_pct = 78;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct = 0;
               rx_stall_pct = 78;
            end
            default: begin
               tx_idle_pct = 31;
               rx_stall_pct = 31;
            end
         endcase
         if (phase == 4) hold_request = 1'b1;
         repeat (ITEMS_PER_PHASE) begin
            if (msg_left == 0) begin
               case ($urandom_range(9))
                  0: msg_left = 64;
                  1: msg_left = 128;
                  2: msg_left = 1;
                  3, 4, 5: msg_left = $urandom_range(16, 2);
                  default: msg_left = $urandom_range(200, 17);
               endcase
            end
            msg_left--;
            item.data_byte = $urandom_range(255);
            item.message_end = (msg_left == 0);
            send_byte(item, 1'b0, '0);
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/cc20_pkg.sv
hw/rtl/cc20_front.sv
hw/rtl/cc20_back.sv
hw/rtl/chacha20_stream_cipher.sv
tb/sv/tb_top.sv
